@@ src/hid_keyboard_report_tracker_macros.svh @@
// assertion macros used by the keyboard report tracker checker
`ifndef HID_KEYBOARD_REPORT_TRACKER_MACROS_SVH
`define HID_KEYBOARD_REPORT_TRACKER_MACROS_SVH

// property a implies c in the next cycle, skipped while reset is held
`define HKRT_ASSERT_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (c)) \
        else $error("hkrt check failed");

// property a implies c in the next cycle, checked during reset too
`define HKRT_ASSERT_NEXT_ALWAYS(lbl, clk, a, c) \
    lbl: assert property (@(posedge clk) (a) |=> (c)) \
        else $error("hkrt check failed");

`endif

@@ src/hkrt_pkg.sv @@
// types, constants and helpers of the keyboard report tracker
package hkrt_pkg;

    localparam int KEY_SLOTS = 6;
    localparam int OUT_SLOTS = 6;
    localparam int SLOT_IW   = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

    typedef logic [7:0]         t_key;
    typedef logic [SLOT_IW-1:0] t_slot_idx;
    typedef logic [KEY_SLOTS-1:0][7:0] t_slot_vec;
    typedef logic [OUT_SLOTS-1:0][7:0] t_out_vec;

    localparam t_slot_idx LAST_IDX = t_slot_idx'(KEY_SLOTS - 1);

    localparam logic OP_RELEASE = 1'b0;
    localparam logic OP_PRESS   = 1'b1;

    localparam t_key MOD_LO  = 8'hE0;
    localparam t_key MOD_HI  = 8'hE7;
    localparam t_key KEY_LO  = 8'h04;
    localparam t_key KEY_HI  = 8'hA4;
    localparam t_key EMPTY_KEY = 8'h00;
    localparam logic [2:0] MOD_BIT_MASK = 3'h7;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    // slot write port
    typedef struct packed {
        logic      en;
        t_slot_idx idx;
        t_key      data;
    } t_slot_wr;

    // shared compare unit result for the addressed slot
    typedef struct packed {
        logic hit;
        logic empty;
    } t_slot_cmp;

    function automatic logic is_modifier(input t_key c);
        return (c >= MOD_LO) && (c <= MOD_HI);
    endfunction

    function automatic logic is_plain_key(input t_key c);
        return (c >= KEY_LO) && (c <= KEY_HI);
    endfunction

endpackage

@@ src/hkrt_if.sv @@
// handshake channels of the keyboard report tracker
interface hkrt_evt_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] usage_code;

    modport source (output valid, output op, output usage_code, input ready);
    modport sink   (input valid, input op, input usage_code, output ready);
endinterface

interface hkrt_rpt_if;
    logic       valid;
    logic       ready;
    logic [7:0] modifier_mask;
    logic [7:0] slot_0;
    logic [7:0] slot_1;
    logic [7:0] slot_2;
    logic [7:0] slot_3;
    logic [7:0] slot_4;
    logic [7:0] slot_5;

    modport source (output valid, output modifier_mask, output slot_0, output slot_1,
                    output slot_2, output slot_3, output slot_4, output slot_5,
                    input ready);
    modport sink   (input valid, input modifier_mask, input slot_0, input slot_1,
                    input slot_2, input slot_3, input slot_4, input slot_5,
                    output ready);
endinterface

@@ src/hid_keyboard_report_tracker.sv @@
// boot keyboard report tracker: sequencer, modifier mask and report register
// modifier events go straight to the report, key events first go through the slot scan
// ignored codes are taken without a report; the scan checks one slot per cycle
// through the shared slot comparator; ready is low while an event is in work
// a finished report waits in the output register while the next event is taken
// reset (i_rst_n low, synchronous) empties all slots, clears the mask and drops any pending report
module hid_keyboard_report_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hkrt_evt_if.sink    i_evt,
    hkrt_rpt_if.source  o_rpt
);
    import hkrt_pkg::*;

    t_state    r_state, n_state;
    logic      r_op;
    t_key      r_code;
    t_slot_idx r_idx, n_idx;
    logic      r_free_ok, n_free_ok;
    t_slot_idx r_free_idx, n_free_idx;
    logic [7:0] r_mods, n_mods;

    logic      r_out_valid, n_out_valid;
    logic [7:0] r_out_mods;
    t_out_vec  r_out_slots;
    t_out_vec  report;

    t_slot_wr  slot_wr;
    t_slot_cmp slot_cmp;
    t_slot_vec slots;

    logic      evt_fire;
    logic      out_free;
    logic      out_load;
    logic      scan_last;
    logic [7:0] mod_bit;
    logic      free_now;

    hkrt_slot_file u_slots (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (slot_wr),
        .i_rd_idx (r_idx),
        .i_code   (r_code),
        .o_cmp    (slot_cmp),
        .o_slots  (slots)
    );

    assign i_evt.ready = (r_state == ST_IDLE);
    assign evt_fire    = i_evt.valid && i_evt.ready;

    // output register is free when empty or being taken this cycle
    assign out_free  = !r_out_valid || o_rpt.ready;
    assign out_load  = (r_state == ST_EMIT) && out_free;
    assign scan_last = (r_idx == LAST_IDX);
    assign mod_bit   = 8'(1) << (i_evt.usage_code[2:0] & MOD_BIT_MASK);
    // an empty slot was seen so far, this one included
    assign free_now  = r_free_ok || slot_cmp.empty;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_free_ok  = r_free_ok;
        n_free_idx = r_free_idx;
        n_mods     = r_mods;
        slot_wr    = '{en: 1'b0, idx: r_idx, data: EMPTY_KEY};

        unique case (r_state)
            ST_IDLE: begin
                if (evt_fire) begin
                    n_idx     = '0;
                    n_free_ok = 1'b0;
                    if (is_modifier(i_evt.usage_code)) begin
                        // modifiers are settled at once, report only on a real change
                        if (i_evt.op == OP_PRESS) begin
                            n_mods = r_mods | mod_bit;
                        end else begin
                            n_mods = r_mods & ~mod_bit;
                        end
                        if (n_mods != r_mods) begin
                            n_state = ST_EMIT;
                        end
                    end else if (is_plain_key(i_evt.usage_code)) begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_op == OP_PRESS) begin
                    if (slot_cmp.hit) begin
                        // already held: nothing changes
                        n_state = ST_IDLE;
                    end else begin
                        if (!r_free_ok && slot_cmp.empty) begin
                            n_free_ok  = 1'b1;
                            n_free_idx = r_idx;
                        end
                        if (scan_last) begin
                            if (free_now) begin
                                slot_wr = '{en: 1'b1,
                                            idx: (r_free_ok ? r_free_idx : r_idx),
                                            data: r_code};
                                n_state = ST_EMIT;
                            end else begin
                                // all slots full: drop the press
                                n_state = ST_IDLE;
                            end
                        end else begin
                            n_idx = t_slot_idx'(r_idx + 1'b1);
                        end
                    end
                end else begin
                    if (slot_cmp.hit) begin
                        // first matching slot is emptied
                        slot_wr = '{en: 1'b1, idx: r_idx, data: EMPTY_KEY};
                        n_state = ST_EMIT;
                    end else if (scan_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = t_slot_idx'(r_idx + 1'b1);
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // report image: slot fields past the slot count read as empty
    always_comb begin
        report = '0;
        for (int j = 0; j < OUT_SLOTS; j++) begin
            if (j < KEY_SLOTS) begin
                report[j] = slots[j];
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_rpt.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_free_ok   <= 1'b0;
            r_mods      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_free_ok   <= n_free_ok;
            r_mods      <= n_mods;
            r_out_valid <= n_out_valid;
        end
    end

    // event and report payload
    always_ff @(posedge i_clk) begin
        r_free_idx <= n_free_idx;
        if (evt_fire) begin
            r_op   <= i_evt.op;
            r_code <= i_evt.usage_code;
        end
        if (out_load) begin
            r_out_mods  <= r_mods;
            r_out_slots <= report;
        end
    end

    assign o_rpt.valid         = r_out_valid;
    assign o_rpt.modifier_mask = r_out_mods;
    assign o_rpt.slot_0        = r_out_slots[0];
    assign o_rpt.slot_1        = r_out_slots[1];
    assign o_rpt.slot_2        = r_out_slots[2];
    assign o_rpt.slot_3        = r_out_slots[3];
    assign o_rpt.slot_4        = r_out_slots[4];
    assign o_rpt.slot_5        = r_out_slots[5];

endmodule

@@ src/hkrt_slot_file.sv @@
// key slot registers with one write port and the shared slot comparator
module hkrt_slot_file (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hkrt_pkg::t_slot_wr   i_wr,
    input  hkrt_pkg::t_slot_idx  i_rd_idx,
    input  hkrt_pkg::t_key       i_code,
    output hkrt_pkg::t_slot_cmp  o_cmp,
    output hkrt_pkg::t_slot_vec  o_slots
);
    import hkrt_pkg::*;

    t_slot_vec r_slots;
    t_key      rd_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= '0;
        end else if (i_wr.en) begin
            r_slots[i_wr.idx] <= i_wr.data;
        end
    end

    // one slot per cycle goes through the comparator
    assign rd_key      = r_slots[i_rd_idx];
    assign o_cmp.hit   = (rd_key == i_code);
    assign o_cmp.empty = (rd_key == EMPTY_KEY);
    assign o_slots     = r_slots;

endmodule

@@ src/hkrt_checker.sv @@
// port-level checks of the keyboard report tracker and their bind
`include "hid_keyboard_report_tracker_macros.svh"

module hkrt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_evt_valid,
    input logic       i_evt_ready,
    input logic [7:0] i_evt_code,
    input logic       i_rpt_valid,
    input logic       i_rpt_ready
);
    import hkrt_pkg::*;

    logic evt_fire;
    logic evt_key;
    logic evt_other;

    assign evt_fire  = i_evt_valid && i_evt_ready;
    assign evt_key   = evt_fire && is_plain_key(i_evt_code);
    assign evt_other = evt_fire && !is_plain_key(i_evt_code) && !is_modifier(i_evt_code);

    // a key event always goes through the slot scan
    `HKRT_ASSERT_NEXT(a_key_busy, i_clk, i_rst_n, evt_key, !i_evt_ready)
    // an ignored code leaves the block ready at once
    `HKRT_ASSERT_NEXT(a_other_idle, i_clk, i_rst_n, evt_other, i_evt_ready)
    // a report that is not taken stays offered
    `HKRT_ASSERT_NEXT(a_rpt_hold, i_clk, i_rst_n, i_rpt_valid && !i_rpt_ready, i_rpt_valid)
    // reset drops any pending report
    `HKRT_ASSERT_NEXT_ALWAYS(a_rst_clear, i_clk, !i_rst_n, !i_rpt_valid)

endmodule

bind hid_keyboard_report_tracker hkrt_checker u_hkrt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_evt_valid (i_evt.valid),
    .i_evt_ready (i_evt.ready),
    .i_evt_code  (i_evt.usage_code),
    .i_rpt_valid (o_rpt.valid),
    .i_rpt_ready (o_rpt.ready)
);

@@ dv/tb_top.sv @@
// self-checking testbench of the keyboard report tracker: directed and random key traffic
`timescale 1ns / 1ps

module tb_top;
    import hkrt_pkg::*;

    // run length and safety limits
    localparam int CLK_HALF      = 5;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int MAX_SHOWN     = 10;
    localparam int POOL_SIZE     = 10;
    localparam int HOLDOFF_LEN   = 250;

    // one expected report: modifier mask plus the six visible slots
    typedef struct packed {
        logic [7:0] mods;
        t_out_vec   slots;
    } t_report;

    logic i_clk;
    logic i_rst_n;

    hkrt_evt_if evt_if ();
    hkrt_rpt_if rpt_if ();

    hid_keyboard_report_tracker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_if),
        .o_rpt   (rpt_if)
    );

    // shadow copy of the keyboard state kept by the testbench
    logic [7:0]  shadow_mods;
    t_key        shadow_keys [KEY_SLOTS];
    t_report     report_q [$];

    // knobs shared between the test tasks and the driving processes
    bit          src_idle_en;
    bit          snk_idle_en;
    int          holdoff_left;
    int          n_errors;
    int          cycle_cnt;
    t_key        key_pool [POOL_SIZE];

    // clock
    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // watchdog, counts every cycle of the run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reports still pending",
                     cycle_cnt, report_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // single place where failures are counted; only the first MAX_SHOWN are shown
    task automatic log_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_SHOWN)
            $display("[%0t] %s", $realtime, msg);
    endtask

    // update the shadow keyboard state for one event and queue the report
    // it should produce; returns 1 when the report changed
    function automatic bit predict_report(input logic op, input t_key code);
        logic [7:0] bitmask;
        bit         changed;
        int         free_at;
        bit         dup;
        t_report    rpt;
        changed = 1'b0;
        if (code >= MOD_LO && code <= MOD_HI) begin
            // modifiers map straight onto one mask bit
            bitmask = 8'(1) << (code[2:0] & MOD_BIT_MASK);
            if (op == OP_PRESS) begin
                changed = (shadow_mods & bitmask) == 8'h00;
                shadow_mods = shadow_mods | bitmask;
            end else begin
                changed = (shadow_mods & bitmask) != 8'h00;
                shadow_mods = shadow_mods & ~bitmask;
            end
        end else if (code >= KEY_LO && code <= KEY_HI) begin
            if (op == OP_PRESS) begin
                // a key already held is ignored, else it takes the lowest empty slot
                free_at = -1;
                dup     = 1'b0;
                for (int i = 0; i < KEY_SLOTS; i++) begin
                    if (shadow_keys[i] == code)
                        dup = 1'b1;
                    if (free_at < 0 && shadow_keys[i] == EMPTY_KEY)
                        free_at = i;
                end
                if (!dup && free_at >= 0) begin
                    shadow_keys[free_at] = code;
                    changed = 1'b1;
                end
            end else begin
                // release clears only the first matching slot
                for (int i = 0; i < KEY_SLOTS; i++) begin
                    if (!changed && shadow_keys[i] == code) begin
                        shadow_keys[i] = EMPTY_KEY;
                        changed = 1'b1;
                    end
                end
            end
        end
        // every other code leaves the report alone
        if (changed) begin
            rpt.mods = shadow_mods;
            for (int j = 0; j < OUT_SLOTS; j++)
                rpt.slots[j] = (j < KEY_SLOTS) ? shadow_keys[j] : EMPTY_KEY;
            report_q.push_back(rpt);
        end
        return changed;
    endfunction

    // offer one key event and wait for its transaction; entered and left
    // just after a falling edge, valid stays high for a back-to-back event
    task automatic send_event(input logic op, input t_key code);
        while (src_idle_en && $urandom_range(99) < 21) begin
            evt_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        evt_if.valid      <= 1'b1;
        evt_if.op         <= op;
        evt_if.usage_code <= code;
        do @(posedge i_clk); while (!evt_if.ready);
        void'(predict_report(op, code));
        @(negedge i_clk);
    endtask

    // report sink: random stalls, plus a long hold-off when a test asks for it
    always @(negedge i_clk) begin
        if (holdoff_left > 0) begin
            rpt_if.ready <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end else if (snk_idle_en) begin
            rpt_if.ready <= ($urandom_range(99) >= 21);
        end else begin
            rpt_if.ready <= 1'b1;
        end
    end

    // report checker: every report transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_report  want;
        t_out_vec got_slots;
        if (i_rst_n && rpt_if.valid && rpt_if.ready) begin
            got_slots = {rpt_if.slot_5, rpt_if.slot_4, rpt_if.slot_3,
                         rpt_if.slot_2, rpt_if.slot_1, rpt_if.slot_0};
            if (report_q.size() == 0) begin
                log_error($sformatf("unexpected report mods %02h slots %h",
                                    rpt_if.modifier_mask, got_slots));
            end else begin
                want = report_q.pop_front();
                if (want.mods !== rpt_if.modifier_mask)
                    log_error($sformatf("modifier mask: expected %02h, got %02h",
                                        want.mods, rpt_if.modifier_mask));
                for (int j = 0; j < OUT_SLOTS; j++) begin
                    if (want.slots[j] !== got_slots[j])
                        log_error($sformatf("slot_%0d: expected %02h, got %02h",
                                            j, want.slots[j], got_slots[j]));
                end
            end
        end
    end

    // modifier corners: both ends of the range, repeated press, release of
    // a modifier that is not held
    task automatic test_modifiers();
        send_event(OP_PRESS,   MOD_LO);
        send_event(OP_PRESS,   MOD_HI);
        send_event(OP_PRESS,   MOD_LO);
        send_event(OP_RELEASE, MOD_HI);
        send_event(OP_RELEASE, MOD_HI);
        send_event(OP_RELEASE, MOD_LO);
    endtask

    // key slots: both ends of the key range, fill all slots, drop on full,
    // repeated press, refill of a hole, release of a key not held
    task automatic test_key_slots();
        send_event(OP_PRESS,   KEY_LO);
        send_event(OP_PRESS,   KEY_HI);
        send_event(OP_PRESS,   8'h10);
        send_event(OP_PRESS,   8'h11);
        send_event(OP_PRESS,   8'h12);
        send_event(OP_PRESS,   8'h13);
        send_event(OP_PRESS,   8'h20);   // all slots taken, dropped
        send_event(OP_PRESS,   8'h10);   // already held
        send_event(OP_RELEASE, 8'h11);
        send_event(OP_PRESS,   8'h21);   // lands in the hole just opened
        send_event(OP_RELEASE, 8'h55);   // never pressed
    endtask

    // codes just outside both ranges and the far ends of the byte
    task automatic test_ignored_codes();
        send_event(OP_PRESS,   8'h00);
        send_event(OP_RELEASE, 8'hFF);
        send_event(OP_PRESS,   KEY_LO - 8'h01);
        send_event(OP_PRESS,   KEY_HI + 8'h01);
        send_event(OP_PRESS,   MOD_LO - 8'h01);
        send_event(OP_RELEASE, MOD_HI + 8'h01);
    endtask

    // random typing: mostly presses and releases from a small key pool so that
    // slots fill, empty and collide, with modifiers and some raw noise mixed in;
    // sends the given number of events
    task automatic test_random_typing(input int n_events);
        int   pick;
        logic op;
        t_key code;
        for (int k = 0; k < n_events; k++) begin
            if ($urandom_range(99) < 5)
                key_pool[$urandom_range(POOL_SIZE - 1)] = t_key'($urandom_range(KEY_HI, KEY_LO));
            pick = $urandom_range(99);
            if (pick < 40) begin
                op   = OP_PRESS;
                code = key_pool[$urandom_range(POOL_SIZE - 1)];
            end else if (pick < 70) begin
                // release something held most of the time
                op   = OP_RELEASE;
                code = shadow_keys[$urandom_range(KEY_SLOTS - 1)];
                if (code == EMPTY_KEY)
                    code = key_pool[$urandom_range(POOL_SIZE - 1)];
            end else if (pick < 88) begin
                op   = logic'($urandom_range(1));
                code = MOD_LO + t_key'($urandom_range(7));
            end else begin
                op   = logic'($urandom_range(1));
                code = t_key'($urandom_range(255));
            end
            send_event(op, code);
        end
    endtask

    // back-to-back traffic with neither side idling
    task automatic test_no_idle_stretch();
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        test_random_typing(150);
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
    endtask

    // report sink holds off for a long while, the sender keeps pushing so the
    // output register fills and the event input stalls
    task automatic test_receiver_holdoff();
        src_idle_en = 1'b0;
        evt_if.valid <= 1'b0;
        @(posedge i_clk);
        holdoff_left = HOLDOFF_LEN;
        @(negedge i_clk);
        test_random_typing(60);
        src_idle_en = 1'b1;
    endtask

    initial begin
        // known values on every input from time zero
        i_rst_n           = 1'b0;
        evt_if.valid      = 1'b0;
        evt_if.op         = OP_RELEASE;
        evt_if.usage_code = EMPTY_KEY;
        rpt_if.ready      = 1'b0;
        shadow_mods       = 8'h00;
        for (int i = 0; i < KEY_SLOTS; i++)
            shadow_keys[i] = EMPTY_KEY;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = t_key'($urandom_range(KEY_HI, KEY_LO));
        n_errors     = 0;
        cycle_cnt    = 0;
        holdoff_left = 0;
        src_idle_en  = 1'b1;
        snk_idle_en  = 1'b1;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_modifiers();
        test_key_slots();
        test_ignored_codes();
        test_random_typing(480);
        test_no_idle_stretch();
        test_receiver_holdoff();
        test_random_typing(480);

        evt_if.valid <= 1'b0;

        // drain, then give the block time to emit anything it should not
        while (report_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d errors", n_errors);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
